// ----- sv/afbc_pkg.sv -----
package afbc_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NWORDS  = 8;
    localparam int unsigned BLOCK_W = WORD_W * NWORDS;
    localparam int unsigned USER_W  = 1;

    // block as eight 32-bit words, word 0 in the low bits
    typedef logic [NWORDS-1:0][WORD_W-1:0] blk_t;

    typedef enum logic [USER_W-1:0] {
        OP_FORWARD = 1'b0,
        OP_INVERSE = 1'b1
    } op_t;

    localparam logic [WORD_W-1:0] M_TOP1      = 32'h8000_0000;
    localparam logic [WORD_W-1:0] M_HI15      = 32'h7fff_0000;
    localparam logic [WORD_W-1:0] M_HI16      = 32'hffff_0000;
    localparam logic [WORD_W-1:0] M_C000      = 32'hc000_c000;
    localparam logic [WORD_W-1:0] M_3F00      = 32'h3f00_3f00;
    localparam logic [WORD_W-1:0] M_FF00      = 32'hff00_ff00;
    localparam logic [WORD_W-1:0] M_8080      = 32'h8080_8080;
    localparam logic [WORD_W-1:0] M_7070      = 32'h7070_7070;
    localparam logic [WORD_W-1:0] M_F0F0      = 32'hf0f0_f0f0;
    localparam logic [WORD_W-1:0] M_F000      = 32'hf000_f000;
    localparam logic [WORD_W-1:0] M_0F00      = 32'h0f00_0f00;
    localparam logic [WORD_W-1:0] M_8888      = 32'h8888_8888;
    localparam logic [WORD_W-1:0] M_4444      = 32'h4444_4444;
    localparam logic [WORD_W-1:0] M_CCCC      = 32'hcccc_cccc;

    // masked in-word fold applied to every word
    function automatic blk_t fold_all(blk_t v, logic [WORD_W-1:0] mask, int unsigned sh);
        blk_t w;
        for (int k = 0; k < NWORDS; k++)
        begin
            w[k] = v[k] ^ ((v[k] & mask) >> sh);
        end
        return w;
    endfunction

    function automatic blk_t forward_net(blk_t v_in);
        blk_t v;
        v = v_in;
        // byte fold over 120-bit distance
        v[4] ^= v[7] >> 24;
        v[3] ^= (v[7] << 8) ^ (v[6] >> 24);
        v[2] ^= (v[6] << 8) ^ (v[5] >> 24);
        v[1] ^= (v[5] << 8) ^ (v[4] >> 24);
        v[0] ^= v[4] << 8;
        for (int k = 0; k < NWORDS; k += 4)
        begin
            v[k+2] ^= v[k+3] >> 28;
            v[k+1] ^= (v[k+3] << 4) ^ (v[k+2] >> 28);
            v[k]   ^= v[k+2] << 4;
        end
        for (int k = 0; k < NWORDS; k += 2)
        begin
            v[k+1] ^= v[k+1] >> 30;
            v[k]   ^= v[k+1] << 2;
        end
        v = fold_all(v, M_TOP1, 15);
        v = fold_all(v, M_HI15, 15);
        v[4] ^= v[7];
        v[3] ^= v[6];
        v[2] ^= v[5];
        v[1] ^= v[4];
        for (int k = 0; k < NWORDS; k += 4)
        begin
            v[k+2] ^= v[k+3] >> 16;
            v[k+1] ^= (v[k+3] << 16) ^ (v[k+2] >> 16);
            v[k]   ^= v[k+2] << 16;
        end
        v[5] ^= v[7];
        v[4] ^= v[6];
        v[3] ^= v[5];
        v[2] ^= v[4];
        for (int k = 0; k < NWORDS; k += 2)
        begin
            v[k+1] ^= v[k+1] >> 16;
            v[k]   ^= v[k+1] << 16;
        end
        v = fold_all(v, M_C000, 6);
        v = fold_all(v, M_3F00, 6);
        v = fold_all(v, M_8080, 3);
        v = fold_all(v, M_7070, 3);
        v = fold_all(v, M_F000, 4);
        v = fold_all(v, M_0F00, 4);
        v = fold_all(v, M_8888, 1);
        v = fold_all(v, M_4444, 1);
        return v;
    endfunction

    function automatic blk_t inverse_net(blk_t v_in);
        blk_t v;
        v = v_in;
        v = fold_all(v, M_CCCC, 1);
        v = fold_all(v, M_FF00, 4);
        v = fold_all(v, M_F0F0, 3);
        v = fold_all(v, M_FF00, 6);
        for (int k = 0; k < NWORDS; k += 2)
        begin
            v[k]   ^= v[k+1] << 16;
            v[k+1] ^= v[k+1] >> 16;
        end
        v[3] ^= v[5];
        v[2] ^= v[4];
        v[5] ^= v[7];
        v[4] ^= v[6];
        for (int k = 0; k < NWORDS; k += 4)
        begin
            v[k]   ^= v[k+2] << 16;
            v[k+1] ^= (v[k+3] << 16) ^ (v[k+2] >> 16);
            v[k+2] ^= v[k+3] >> 16;
        end
        v[1] ^= v[4];
        v[2] ^= v[5];
        v[3] ^= v[6];
        v[4] ^= v[7];
        v = fold_all(v, M_HI16, 15);
        for (int k = 0; k < NWORDS; k += 2)
        begin
            v[k]   ^= v[k+1] << 2;
            v[k+1] ^= v[k+1] >> 30;
        end
        for (int k = 0; k < NWORDS; k += 4)
        begin
            v[k]   ^= v[k+2] << 4;
            v[k+1] ^= (v[k+3] << 4) ^ (v[k+2] >> 28);
            v[k+2] ^= v[k+3] >> 28;
        end
        v[0] ^= v[4] << 8;
        v[1] ^= (v[5] << 8) ^ (v[4] >> 24);
        v[2] ^= (v[6] << 8) ^ (v[5] >> 24);
        v[3] ^= (v[7] << 8) ^ (v[6] >> 24);
        v[4] ^= v[7] >> 24;
        return v;
    endfunction

endpackage

// ----- sv/afbc_net.sv -----
module afbc_net
(
    input  afbc_pkg::op_t  op,
    input  afbc_pkg::blk_t blk_in,
    output afbc_pkg::blk_t blk_out
);

    afbc_pkg::blk_t fwd;
    afbc_pkg::blk_t inv;

    assign fwd = afbc_pkg::forward_net(blk_in);
    assign inv = afbc_pkg::inverse_net(blk_in);

    always_comb
    begin
        unique case (op)
            afbc_pkg::OP_FORWARD: blk_out = fwd;
            afbc_pkg::OP_INVERSE: blk_out = inv;
            default:              blk_out = fwd;
        endcase
    end

endmodule

// ----- sv/additive_fft_block_basis_convert_top.sv -----
// channel | direction | tdata                                   | tuser
// s_*     | in        | in_word0..in_word3, 64 bits each        | operation
// m_*     | out       | out_word0..out_word3, 64 bits each      | -
//
// one block per cycle sustained while m_tready stays high; a block passes from input to output
// transaction through the input register, the xor network and the result register
// rst_n clears only the valid flags; data registers are not reset
// a stalled output still lets one more block into the input register
// s_tready depends combinationally on m_tready
module additive_fft_block_basis_convert_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [afbc_pkg::BLOCK_W-1:0]          s_tdata,  // in_word0, in_word1, in_word2, in_word3
    input  logic [afbc_pkg::USER_W-1:0]           s_tuser,  // operation
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [afbc_pkg::BLOCK_W-1:0]          m_tdata   // out_word0, out_word1, out_word2, out_word3
);

    logic           in_valid_reg;
    afbc_pkg::blk_t in_blk_reg;
    afbc_pkg::op_t  in_op_reg;
    logic           out_valid_reg;
    afbc_pkg::blk_t out_blk_reg;
    afbc_pkg::blk_t net_blk;
    logic           out_load;
    logic           in_load;

    // result register can take a new block when empty or being drained
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    afbc_net u_net
    (
        .op      (in_op_reg),
        .blk_in  (in_blk_reg),
        .blk_out (net_blk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_blk_reg <= afbc_pkg::blk_t'(s_tdata);
            in_op_reg  <= afbc_pkg::op_t'(s_tuser);
        end
        if (out_load && in_valid_reg)
        begin
            out_blk_reg <= net_blk;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_blk_reg;

    // both registers full and output stalled: no new transaction
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    // a result only appears after a block sat in the input register
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result appeared without a source block");

    // a held input block moves into the result register when it has room
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("input block lost on advance");

endmodule
